// ===== design/bsfm_pkg.sv =====
// Shared types and constants for the bitmap first-missing-value block.
package bsfm_pkg;

  // Defaults for the top-level parameters
  localparam int VALUE_BITS_DEF = 16;
  localparam int WORD_BITS_DEF  = 32;

  // Fixed widths of the transaction fields
  localparam int VAL_W = 16;

  // Item kinds
  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_SCAN,
    ST_RESULT
  } state_t;

endpackage

// ===== design/bitmap_set_first_missing_core.sv =====
// Bitmap set with add and find-first-missing-value query, held in a word memory.
//
// A presence bitmap over the values 0 .. 2**VALUE_BITS-1 lives in one
// synchronous memory of ceil(2**VALUE_BITS / WORD_BITS) words, WORD_BITS bits
// each, with a registered read port. After reset the block runs a clearing
// pass that writes one word per cycle; in_ready stays low until all DEPTH
// words (2048 with the default parameters) are written. An add transaction
// (kind 0) sets the bit of its value (wrapped to VALUE_BITS bits) in steps:
// accept with the word index worked out by a reciprocal multiply, memory
// read, then read-modify-write back. An add produces no result transaction.
// A query transaction (kind 1) reads the words from address 0 upward, one per
// cycle, and stops at the first word with a clear bit. The result holds the
// smallest missing value with found=1, or found=0 and missing_value=0 when
// the set is full. Results wait in an output register, so an add may be
// accepted while the previous query result is still held; a query that
// finishes while the register is still occupied waits until it is taken.
// Only one transaction is in progress at a time, which rules out any overlap
// on a memory word.
module bitmap_set_first_missing_core
  import bsfm_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int WORD_BITS  = WORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  // input channel
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_kind,
  input  logic [VAL_W-1:0] in_value,
  // result channel
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_found,
  output logic [VAL_W-1:0] out_missing_value
);

  // ---------------------------------------------------------------------------
  // Derived sizes
  // ---------------------------------------------------------------------------
  localparam longint unsigned DEPTH_L =
    ((64'd1 << VALUE_BITS) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS);
  localparam int DEPTH  = int'(DEPTH_L);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BIT_W  = $clog2(WORD_BITS);

  // word index = (val * MULT) >> SHIFT, exact for every val < 2**VALUE_BITS
  localparam int SHIFT  = VALUE_BITS + BIT_W;
  localparam int MULT_W = VALUE_BITS + 1;
  localparam longint unsigned MULT_L =
    ((64'd1 << SHIFT) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS);
  localparam logic [MULT_W-1:0] MULT = MULT_W'(MULT_L);
  localparam int PROD_W = VALUE_BITS + MULT_W;

  localparam int REM_W = VALUE_BITS + 8;   // room for q * WORD_BITS
  localparam int POS_W = VALUE_BITS + 2;   // absolute bit position of a hit

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_t                state_r, state_nxt;
  logic [ADDR_W-1:0]     clr_addr_r, clr_addr_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [ADDR_W-1:0]     q_r, q_nxt;
  logic [BIT_W-1:0]      bit_r, bit_nxt;
  logic [ADDR_W-1:0]     scan_addr_r, scan_addr_nxt;
  logic                  scan_last_r, scan_last_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [ADDR_W-1:0]     rd_addr_r, rd_addr_nxt;
  logic [ADDR_W-1:0]     hit_addr_r, hit_addr_nxt;
  logic [BIT_W-1:0]      hit_bit_r, hit_bit_nxt;
  logic                  hit_none_r, hit_none_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_found_r, out_found_nxt;
  logic [VAL_W-1:0]      out_missing_r, out_missing_nxt;

  // memory
  logic [WORD_BITS-1:0]  mem [DEPTH];
  logic [WORD_BITS-1:0]  rd_data_r;
  logic [ADDR_W-1:0]     mem_raddr;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [WORD_BITS-1:0]  mem_wdata;

  // ---------------------------------------------------------------------------
  // Datapath helpers
  // ---------------------------------------------------------------------------
  logic [31:0]           in_ext;
  logic [VALUE_BITS-1:0] in_val;
  logic [PROD_W-1:0]     in_prod;
  logic [REM_W-1:0]      rem;
  logic [BIT_W-1:0]      zero_bit;
  logic                  word_full;
  logic [POS_W-1:0]      hit_pos;
  logic                  res_found;

  // wrap the value to the domain
  assign in_ext  = 32'(in_value);
  assign in_val  = in_ext[VALUE_BITS-1:0];
  assign in_prod = PROD_W'(in_val) * PROD_W'(MULT);

  // bit within the word, from the registered quotient
  assign rem = REM_W'(val_r) - REM_W'(q_r) * REM_W'(WORD_BITS);

  // lowest clear bit of the word being checked
  always_comb begin
    zero_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!rd_data_r[b]) zero_bit = BIT_W'(b);
    end
  end
  assign word_full = &rd_data_r;

  // a clear bit past the domain (partial last word) is not a missing value
  assign hit_pos   = POS_W'(hit_addr_r) * POS_W'(WORD_BITS) + POS_W'(hit_bit_r);
  assign res_found = !hit_none_r && (hit_pos[POS_W-1:VALUE_BITS] == '0);

  // ---------------------------------------------------------------------------
  // Memory: one write port, one registered read port
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[mem_raddr];
  end

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r         <= val_nxt;
    q_r           <= q_nxt;
    bit_r         <= bit_nxt;
    scan_addr_r   <= scan_addr_nxt;
    scan_last_r   <= scan_last_nxt;
    rd_addr_r     <= rd_addr_nxt;
    hit_addr_r    <= hit_addr_nxt;
    hit_bit_r     <= hit_bit_nxt;
    hit_none_r    <= hit_none_nxt;
    out_found_r   <= out_found_nxt;
    out_missing_r <= out_missing_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    clr_addr_nxt    = clr_addr_r;
    val_nxt         = val_r;
    q_nxt           = q_r;
    bit_nxt         = bit_r;
    scan_addr_nxt   = scan_addr_r;
    scan_last_nxt   = scan_last_r;
    rd_vld_nxt      = 1'b0;
    rd_addr_nxt     = rd_addr_r;
    hit_addr_nxt    = hit_addr_r;
    hit_bit_nxt     = hit_bit_r;
    hit_none_nxt    = hit_none_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_found_nxt   = out_found_r;
    out_missing_nxt = out_missing_r;
    in_ready        = 1'b0;
    mem_raddr       = q_r;
    mem_we          = 1'b0;
    mem_waddr       = q_r;
    mem_wdata       = rd_data_r | (WORD_BITS'(1) << bit_r);

    case (state_r)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ADDR) state_nxt = ST_IDLE;
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == KIND_ADD) begin
            val_nxt   = in_val;
            q_nxt     = ADDR_W'(in_prod >> SHIFT);
            state_nxt = ST_READ;
          end else begin
            scan_addr_nxt = '0;
            scan_last_nxt = 1'b0;
            state_nxt     = ST_SCAN;
          end
        end
      end

      ST_READ: begin
        mem_raddr = q_r;
        bit_nxt   = rem[BIT_W-1:0];
        state_nxt = ST_WRITE;
      end

      ST_WRITE: begin
        mem_we    = 1'b1;
        state_nxt = ST_IDLE;
      end

      ST_SCAN: begin
        // issue one read a cycle, check the word read the cycle before
        mem_raddr = scan_addr_r;
        if (!scan_last_r) begin
          rd_vld_nxt  = 1'b1;
          rd_addr_nxt = scan_addr_r;
          if (scan_addr_r == LAST_ADDR) scan_last_nxt = 1'b1;
          else scan_addr_nxt = scan_addr_r + 1'b1;
        end
        if (rd_vld_r) begin
          if (!word_full) begin
            hit_addr_nxt = rd_addr_r;
            hit_bit_nxt  = zero_bit;
            hit_none_nxt = 1'b0;
            rd_vld_nxt   = 1'b0;
            state_nxt    = ST_RESULT;
          end else if (rd_addr_r == LAST_ADDR) begin
            hit_none_nxt = 1'b1;
            rd_vld_nxt   = 1'b0;
            state_nxt    = ST_RESULT;
          end
        end
      end

      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_found_nxt   = res_found;
          out_missing_nxt = res_found ? VAL_W'(hit_pos) : '0;
          state_nxt       = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_missing_value = out_missing_r;

endmodule

// ===== verif/tb.sv =====
// Testbench for bitmap_set_first_missing_core: scoreboard of smallest missing values.
`timescale 1ns / 100ps

module tb;
  import bsfm_pkg::*;

  // Geometry of the presence bitmap, from the package defaults the block is built with
  localparam int DOMAIN_SIZE   = 1 << VALUE_BITS_DEF;
  localparam int PRESENT_DEPTH = (DOMAIN_SIZE + WORD_BITS_DEF - 1) / WORD_BITS_DEF;
  // Run ceiling, several times the slowest possible run (every item a full-depth scan)
  localparam int RUN_LIMIT_NS  = 20_000_000;
  // Cycles to wait after the last result so a trailing add can settle
  localparam int SETTLE_CYCLES = 16;

  typedef logic [WORD_BITS_DEF-1:0] present_word_t;

  // One expected query answer
  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] value;
  } gap_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  logic             in_kind   = KIND_ADD;
  logic [VAL_W-1:0] in_value  = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_found;
  logic [VAL_W-1:0] out_missing_value;

  // Mirror of the block's presence bitmap, updated as each add is accepted
  present_word_t present_words [PRESENT_DEPTH] = '{default: '0};
  // Answers of accepted queries, oldest first
  gap_t          gap_results [$];
  gap_t          seen_gap;

  int   error_count = 0;
  bit   in_idle_on  = 1'b1;
  logic out_idle_on = 1'b1;
  // Receiver hold-off, counted down by the receiver process
  int   hold_cnt    = 0;

  bitmap_set_first_missing_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_missing_value (out_missing_value)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #RUN_LIMIT_NS;
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Set the bit of a value, wrapped to the domain first
  function automatic void mark_value(input logic [VAL_W-1:0] value);
    int val;
    val = int'(value) & (DOMAIN_SIZE - 1);
    present_words[val / WORD_BITS_DEF][val % WORD_BITS_DEF] = 1'b1;
  endfunction

  // Smallest value whose bit is clear; found=0, value 0 once the domain is full.
  // Bits of a partial last word that lie past the domain are never reported.
  function automatic gap_t first_gap();
    gap_t g;
    int   v;
    g = '0;
    for (int w = 0; w < PRESENT_DEPTH; w++) begin
      if (present_words[w] != '1) begin
        for (int b = 0; b < WORD_BITS_DEF; b++) begin
          v = w * WORD_BITS_DEF + b;
          if (v >= DOMAIN_SIZE) return g;
          if (!present_words[w][b]) begin
            g.found = 1'b1;
            g.value = v[VAL_W-1:0];
            return g;
          end
        end
      end
    end
    return g;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random ready, long hold-offs on request, and the checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      out_ready <= 1'b0;
      hold_cnt  <= hold_cnt - 1;
    end else begin
      out_ready <= !(out_idle_on && $urandom_range(99) < 14);
    end
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Values read right after the edge are the ones the block saw at that edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (gap_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result found=%0b missing_value=%0d",
                                  out_found, out_missing_value));
      end else begin
        seen_gap = gap_results.pop_front();
        if (out_found !== seen_gap.found)
          report_mismatch($sformatf("found %0b, expected %0b", out_found, seen_gap.found));
        if (out_missing_value !== seen_gap.value)
          report_mismatch($sformatf("missing_value %0d, expected %0d",
                                    out_missing_value, seen_gap.value));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one transaction and return at the edge where it is taken. Valid is
  // only lowered inside an idle gap, so a following item never sees valid
  // dropped and raised in the same step.
  task automatic send_item(input logic kind, input logic [VAL_W-1:0] value);
    while (in_idle_on && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    if (kind == KIND_ADD) mark_value(value);
    else gap_results.push_back(first_gap());
  endtask

  // Stop offering and wait until every pending answer has come back
  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (gap_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty set, domain ends, word edges, duplicates, queries with junk in value
  task automatic test_directed_edges();
    send_item(KIND_QUERY, 16'hFFFF);   // empty set answers 0
    send_item(KIND_ADD,   16'h0000);
    send_item(KIND_QUERY, 16'h0000);
    send_item(KIND_ADD,   16'hFFFF);   // top of the domain
    send_item(KIND_QUERY, 16'h1234);
    send_item(KIND_ADD,   16'd1);
    send_item(KIND_ADD,   16'd3);
    send_item(KIND_QUERY, 16'd0);      // hole at 2
    send_item(KIND_ADD,   16'd2);
    send_item(KIND_QUERY, 16'd0);
    send_item(KIND_ADD,   16'd0);      // duplicate add is harmless
    send_item(KIND_QUERY, 16'hAAAA);
    send_item(KIND_ADD,   16'd31);     // last bit of word 0
    send_item(KIND_ADD,   16'd32);     // first bit of word 1
    send_item(KIND_ADD,   16'h8000);
    send_item(KIND_ADD,   16'h5555);
    send_item(KIND_ADD,   16'hAAAA);
    send_item(KIND_ADD,   16'h7FFF);
    send_item(KIND_QUERY, 16'h5555);
    wait_results_done();
  endtask

  // Mostly adds just past the current first gap, so the answer keeps moving
  // across word edges; the rest are duplicates, far noise and queries.
  task automatic test_random_mix();
    gap_t gap;
    int   pick;
    for (int i = 0; i < 300; i++) begin
      gap  = first_gap();
      pick = $urandom_range(99);
      if (pick < 25)
        send_item(KIND_QUERY, VAL_W'($urandom));
      else if (pick < 80)
        send_item(KIND_ADD, VAL_W'(gap.value + $urandom_range(40)));
      else if (pick < 90)
        send_item(KIND_ADD, VAL_W'($urandom_range(gap.value)));
      else
        send_item(KIND_ADD, VAL_W'($urandom));
    end
    wait_results_done();
  endtask

  // Receiver goes quiet while queries and adds keep coming: the output
  // register fills, the next query parks behind it and the input stalls.
  task automatic test_output_stall();
    gap_t gap;
    for (int round = 0; round < 2; round++) begin
      hold_cnt <= (round == 0) ? 300 : 80;
      for (int i = 0; i < 8; i++) begin
        gap = first_gap();
        if (i % 2 == 0)
          send_item(KIND_QUERY, VAL_W'($urandom));
        else
          send_item(KIND_ADD, VAL_W'(gap.value + $urandom_range(3)));
      end
      wait_results_done();
    end
  endtask

  // Long stretch with neither side idling
  task automatic test_back_to_back();
    in_idle_on  = 1'b0;
    out_idle_on <= 1'b0;
    for (int i = 0; i < 120; i++) begin
      if ($urandom_range(99) < 20)
        send_item(KIND_QUERY, VAL_W'($urandom));
      else
        send_item(KIND_ADD, VAL_W'($urandom));
    end
    wait_results_done();
    in_idle_on  = 1'b1;
    out_idle_on <= 1'b1;
  endtask

  // Fill the low 256 values in shuffled order, then query; the answer ends up
  // at or past the filled block, across several word edges.
  task automatic test_fill_low_block();
    int mask;
    mask = $urandom_range(255);
    for (int i = 0; i < 256; i++)
      send_item(KIND_ADD, VAL_W'(i ^ mask));
    send_item(KIND_QUERY, 16'h0000);
    send_item(KIND_ADD,   16'h00FF);   // re-adding a present value changes nothing
    send_item(KIND_QUERY, 16'hFFFF);
    wait_results_done();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    test_random_mix();
    test_output_stall();
    test_back_to_back();
    test_fill_low_block();

    // Everything answered; give a trailing add time to retire
    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/bsfm_pkg.sv
design/bitmap_set_first_missing_core.sv
verif/tb.sv
